@@ sv/name_keyed_nibble_swap_xor_decrypt_macros.svh @@
// assertion helpers included by the decryptor rtl
`ifndef NAME_KEYED_NIBBLE_SWAP_XOR_DECRYPT_MACROS_SVH
`define NAME_KEYED_NIBBLE_SWAP_XOR_DECRYPT_MACROS_SVH

// property holds at every clock edge outside reset
`define NKSXD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: always");

// consequent holds in the cycle after the antecedent
`define NKSXD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`endif

@@ sv/nksxd_pkg.sv @@
package nksxd_pkg;

   localparam int MAX_KEY_BYTES_DEF = 256;
   localparam int CHUNK_W           = 16;
   localparam int BYTE_W            = 8;
   localparam int CMD_W             = 2;

   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NAME  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

   // rotating mask applied to name bytes
   function automatic logic [BYTE_W-1:0] name_mask(input logic [1:0] pos);
      logic [BYTE_W-1:0] m;
      unique case (pos)
         2'd0: m = 8'hEC;
         2'd1: m = 8'hCA;
         2'd2: m = 8'h79;
         2'd3: m = 8'hF8;
      endcase
      return m;
   endfunction

   function automatic logic [BYTE_W-1:0] nibble_swap(input logic [BYTE_W-1:0] b);
      return {b[3:0], b[7:4]};
   endfunction

endpackage

@@ sv/nksxd_key_ram.sv @@
module nksxd_key_ram
   import nksxd_pkg::*;
#(
   parameter int DEPTH = MAX_KEY_BYTES_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/name_keyed_nibble_swap_xor_decrypt.sv @@
// Byte-stream decryptor keyed by a file name.
// Request channel (req_): tuser carries the command (begin, name byte, data
// byte), tdata the byte. Begin clears the key, its length, the counters and
// the truncation flag. Non-zero name bytes are masked and appended to the
// key memory; name bytes past its capacity are dropped and flagged.
// Data bytes are nibble-swapped, XORed with the current key byte and come
// out on the response channel (rsp_): tdata the plain byte, tuser the
// truncation flag. Begin, name and reserved commands give no response.
// csr_wr_en/csr_wr_data write chunk_size; write it only while idle.
// Throughput: one request per cycle while the receiver does not stall. For
// a data byte, the key memory is read and the read stage loads at the
// accepting edge; the output register, which drives rsp_tvalid, loads once free.
// Reset (synchronous, active high) clears all counters, the flag, chunk_size
// and both pipeline valids; the key memory needs no clearing pass.
// When the receiver stalls, the output register and the read stage hold and
// req_tready drops once both are full; nothing is lost.
module name_keyed_nibble_swap_xor_decrypt
   import nksxd_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  logic [CMD_W-1:0]   req_tuser,   // [1:0] cmd
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_tdata,   // [7:0] plain_byte
   output logic               rsp_tuser,   // [0] key_truncated
   input  logic               csr_wr_en,
   input  logic [CHUNK_W-1:0] csr_wr_data
);

`include "name_keyed_nibble_swap_xor_decrypt_macros.svh"

   localparam int KW = $clog2(MAX_KEY_BYTES);
   localparam int LW = $clog2(MAX_KEY_BYTES + 1);

   logic [CHUNK_W-1:0] chunk_size_ff;
   logic [LW-1:0]      key_len_ff, key_len_in;
   logic [KW-1:0]      key_pos_ff, key_pos_in;
   logic [CHUNK_W-1:0] chunk_pos_ff, chunk_pos_in;
   logic [1:0]         mask_pos_ff, mask_pos_in;
   logic               ovf_ff, ovf_in;

   logic               s1_valid_ff;
   logic [BYTE_W-1:0]  s1_swap_ff;
   logic               s1_use_key_ff;
   logic               s1_trunc_ff;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_data_ff;
   logic               rsp_trunc_ff;

   logic               out_ready, s1_adv, req_acc, data_acc;
   logic               wr_en;
   logic [BYTE_W-1:0]  wr_data, key_byte;
   logic [LW-1:0]      pos_next;
   logic [CHUNK_W-1:0] chunk_next;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_acc    = req_tvalid && req_tready;
   assign data_acc   = req_acc && (req_tuser == CMD_DATA);

   assign pos_next   = LW'(key_pos_ff) + LW'(1);
   assign chunk_next = chunk_pos_ff + CHUNK_W'(1);
   assign wr_data    = req_tdata ^ name_mask(mask_pos_ff);

   always_comb begin
      key_len_in   = key_len_ff;
      key_pos_in   = key_pos_ff;
      chunk_pos_in = chunk_pos_ff;
      mask_pos_in  = mask_pos_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      if (req_acc) begin
         unique case (req_tuser)
            CMD_BEGIN: begin
               key_len_in   = '0;
               key_pos_in   = '0;
               chunk_pos_in = '0;
               mask_pos_in  = '0;
               ovf_in       = 1'b0;
            end
            CMD_NAME: begin
               if (req_tdata != '0) begin
                  if (key_len_ff < LW'(MAX_KEY_BYTES)) begin
                     wr_en       = 1'b1;
                     key_len_in  = key_len_ff + LW'(1);
                     mask_pos_in = mask_pos_ff + 2'd1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            CMD_DATA: begin
               // wrap at key length, also covers the empty key
               if (pos_next >= key_len_ff) begin
                  key_pos_in = '0;
               end else begin
                  key_pos_in = pos_next[KW-1:0];
               end
               chunk_pos_in = chunk_next;
               if (chunk_size_ff != '0 && chunk_next == chunk_size_ff) begin
                  chunk_pos_in = '0;
                  key_pos_in   = '0;
               end
            end
            CMD_RSVD: begin
            end
         endcase
      end
   end

   // write address is the key length, read address stays below it unless the key is empty
   nksxd_key_ram #(
      .DEPTH (MAX_KEY_BYTES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (key_len_ff[KW-1:0]),
      .wr_data (wr_data),
      .rd_en   (data_acc),
      .rd_addr (key_pos_ff),
      .rd_data (key_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= '0;
         key_len_ff    <= '0;
         key_pos_ff    <= '0;
         chunk_pos_ff  <= '0;
         mask_pos_ff   <= '0;
         ovf_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chunk_size_ff <= csr_wr_data;
         end
         key_len_ff   <= key_len_in;
         key_pos_ff   <= key_pos_in;
         chunk_pos_ff <= chunk_pos_in;
         mask_pos_ff  <= mask_pos_in;
         ovf_ff       <= ovf_in;
         if (req_tready) begin
            s1_valid_ff <= data_acc;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_acc) begin
         s1_swap_ff    <= nibble_swap(req_tdata);
         s1_use_key_ff <= (key_len_ff != '0);
         s1_trunc_ff   <= ovf_ff;
      end
      if (s1_adv) begin
         rsp_data_ff  <= s1_swap_ff ^ (s1_use_key_ff ? key_byte : '0);
         rsp_trunc_ff <= s1_trunc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_trunc_ff;

   `NKSXD_ASSERT_ALWAYS(a_pos_below_len, clock, reset,
      key_len_ff == '0 || LW'(key_pos_ff) < key_len_ff)
   `NKSXD_ASSERT_ALWAYS(a_len_in_range, clock, reset,
      key_len_ff <= LW'(MAX_KEY_BYTES))
   `NKSXD_ASSERT_NEXT(a_begin_clears, clock, reset,
      req_acc && req_tuser == CMD_BEGIN, key_len_ff == '0 && !ovf_ff)
   `NKSXD_ASSERT_NEXT(a_s1_holds, clock, reset,
      s1_valid_ff && !out_ready,
      s1_valid_ff && $stable(s1_swap_ff) && (!s1_use_key_ff || $stable(key_byte)))

endmodule

@@ tb/name_keyed_nibble_swap_xor_decrypt_tb.sv @@
`timescale 1ns / 100ps

module name_keyed_nibble_swap_xor_decrypt_tb;
   import nksxd_pkg::*;

   localparam int          ITEMS_PER_PHASE = 206;
   localparam int          NUM_PHASES      = 9;
   // name mask bytes, first one in the lowest bits
   localparam logic [31:0] NAME_MASK_WORD  = 32'hF879_CAEC;

   typedef struct packed {
      logic [BYTE_W-1:0] plain;
      logic              truncated;
   } plain_result_type;

   class decrypt_scoreboard;
      logic [BYTE_W-1:0]  key_bytes [MAX_KEY_BYTES_DEF];
      int                 key_len;
      int                 key_idx;
      logic [CHUNK_W-1:0] chunk_cnt;
      logic [1:0]         mask_idx;
      logic               truncated;
      logic [CHUNK_W-1:0] chunk_size;
      plain_result_type   plain_fifo [$];
      int                 errors;

      function new();
         clear_file();
         chunk_size = '0;
         errors     = 0;
      endfunction

      function void clear_file();
         foreach (key_bytes[i]) key_bytes[i] = '0;
         key_len   = 0;
         key_idx   = 0;
         chunk_cnt = '0;
         mask_idx  = '0;
         truncated = 1'b0;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
         plain_result_type  res;
         logic [BYTE_W-1:0] key_byte;
         case (cmd)
            CMD_BEGIN: begin
               clear_file();
            end
            CMD_NAME: begin
               if (b != 0) begin
                  if (key_len < MAX_KEY_BYTES_DEF) begin
                     key_bytes[key_len] = b ^ NAME_MASK_WORD[mask_idx*8 +: 8];
                     key_len++;
                     mask_idx++;
                  end else begin
                     truncated = 1'b1;
                  end
               end
            end
            CMD_DATA: begin
               key_byte = (key_len != 0) ? key_bytes[key_idx] : '0;
               res.plain     = {b[3:0], b[7:4]} ^ key_byte;
               res.truncated = truncated;
               plain_fifo.insert(plain_fifo.size(), res);
               key_idx++;
               if (key_idx >= key_len) key_idx = 0;
               chunk_cnt++;
               if (chunk_size != 0 && chunk_cnt == chunk_size) begin
                  chunk_cnt = '0;
                  key_idx   = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [BYTE_W-1:0] plain, logic trunc);
         plain_result_type exp_res;
         if (plain_fifo.size() == 0) begin
            $display("%0t: unexpected response plain=%h truncated=%b", $time, plain, trunc);
            errors++;
         end else begin
            exp_res = plain_fifo.pop_front();
            if (plain !== exp_res.plain) begin
               $display("%0t: plain byte mismatch: expected %h actual %h",
                        $time, exp_res.plain, plain);
               errors++;
            end
            if (trunc !== exp_res.truncated) begin
               $display("%0t: key_truncated mismatch: expected %b actual %b",
                        $time, exp_res.truncated, trunc);
               errors++;
            end
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata   = '0;
   logic [CMD_W-1:0]   req_tuser   = CMD_BEGIN;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;
   logic               rsp_tuser;
   logic               csr_wr_en   = 1'b0;
   logic [CHUNK_W-1:0] csr_wr_data = '0;

   decrypt_scoreboard  sb;
   int                 send_idle_pct = 19;
   int                 recv_idle_pct = 58;
   int                 items_sent    = 0;

   name_keyed_nibble_swap_xor_decrypt i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, b);
      if (cmd != CMD_RSVD) items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.plain_fifo.size() != 0) @(negedge clock);
      // begin and name requests take effect at acceptance and enter no pipeline
      repeat (4) @(negedge clock);
   endtask

   task automatic write_chunk_size(input logic [CHUNK_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.chunk_size = value;
   endtask

   function automatic logic [BYTE_W-1:0] random_name_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [CHUNK_W-1:0] chunk_plan(input int phase);
      case (phase)
         0:       return 16'd1;
         1:       return 16'd65535;
         2:       return 16'd5;
         3:       return 16'd0;
         4:       return 16'($urandom_range(2, 40));
         5:       return 16'd3;
         6:       return 16'($urandom_range(65535));
         7:       return 16'd2;
         default: return 16'd0;
      endcase
   endfunction

   // one file: optional begin, name, then data with some noise mixed in
   task automatic run_file(input bit start_new, input bit long_name);
      int name_len;
      int data_len;
      int r;
      if (start_new) send_req(CMD_BEGIN, 8'($urandom_range(255)));
      name_len = long_name ? $urandom_range(290, 330) : $urandom_range(0, 12);
      repeat (name_len) send_req(CMD_NAME, random_name_byte());
      data_len = $urandom_range(0, 40);
      repeat (data_len) begin
         r = $urandom_range(99);
         if (r < 3) send_req(CMD_RSVD, 8'($urandom_range(255)));
         else if (r < 6) send_req(CMD_NAME, random_name_byte());
         else if (r < 7) send_req(CMD_BEGIN, 8'($urandom_range(255)));
         send_req(CMD_DATA, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      bit first;
      bit long_name;
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty key straight out of reset
      send_req(CMD_DATA, 8'h00);
      send_req(CMD_DATA, 8'hFF);
      send_req(CMD_DATA, 8'hA5);
      send_req(CMD_RSVD, 8'h5A);
      send_req(CMD_BEGIN, 8'hFF);
      send_req(CMD_NAME, 8'h00);
      send_req(CMD_NAME, 8'hFF);
      send_req(CMD_NAME, 8'h01);
      send_req(CMD_NAME, 8'h80);
      send_req(CMD_NAME, 8'h00);
      send_req(CMD_DATA, 8'h12);
      send_req(CMD_DATA, 8'hFF);
      send_req(CMD_DATA, 8'h00);
      send_req(CMD_DATA, 8'h34);
      // name byte after data keeps the key index
      send_req(CMD_NAME, 8'h7E);
      send_req(CMD_DATA, 8'h00);
      send_req(CMD_DATA, 8'h55);
      send_req(CMD_RSVD, 8'hFF);
      send_req(CMD_BEGIN, 8'h00);
      send_req(CMD_DATA, 8'hC3);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_chunk_size(chunk_plan(p));
         case (p / 3)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         first = 1'b1;
         while (items_sent < (p + 1) * ITEMS_PER_PHASE + 20) begin
            long_name = (first && (p == 1 || p == 7)) || ($urandom_range(49) == 0);
            // the first file of a phase carries on the stream across the write
            run_file(!first && $urandom_range(9) != 0, long_name);
            first = 1'b0;
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[name_keyed_nibble_swap_xor_decrypt] OK");
      end else begin
         $display("[name_keyed_nibble_swap_xor_decrypt] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[name_keyed_nibble_swap_xor_decrypt] ERROR");
      $finish;
   end

endmodule
